### rtl/core/ptrq_pkg.sv
package ptrq_pkg;

  localparam int unsigned ClientW = 16;
  localparam int unsigned TagW    = 32;
  localparam int unsigned PosW    = 4;
  localparam int unsigned CountW  = 5;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_POP    = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_QUERY  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ERR_OK        = 2'd0,
    ERR_FULL      = 2'd1,
    ERR_EMPTY     = 2'd2,
    ERR_POS_RANGE = 2'd3
  } err_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EVAL = 1'b1
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic exec;   // apply accepted word to the queue
    logic load;   // capture the report into the output register
  } ctrl_t;

  typedef struct packed {
    logic               head_valid;
    logic [ClientW-1:0] head_client;
    logic               head_priority;
    logic [TagW-1:0]    head_tag;
    logic [PosW-1:0]    first_free_pos;
    logic [PosW-1:0]    first_limited_pos;
    logic               client_present;
    logic               all_same;
    logic [CountW-1:0]  entry_count;
    logic [1:0]         error_code;
  } result_t;

endpackage

### rtl/core/ptrq_in_if.sv
interface ptrq_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [15:0] entry_client;
  logic        entry_priority;
  logic [31:0] entry_tag;
  logic [3:0]  position;
  logic [15:0] query_client;

  modport source (
    output valid, command, entry_client, entry_priority, entry_tag, position, query_client,
    input  ready
  );
  modport sink (
    input  valid, command, entry_client, entry_priority, entry_tag, position, query_client,
    output ready
  );
endinterface

### rtl/core/ptrq_out_if.sv
interface ptrq_out_if;
  logic        valid;
  logic        ready;
  logic        head_valid;
  logic [15:0] head_client;
  logic        head_priority;
  logic [31:0] head_tag;
  logic [3:0]  first_free_pos;
  logic [3:0]  first_limited_pos;
  logic        client_present;
  logic        all_same;
  logic [4:0]  entry_count;
  logic [1:0]  error_code;

  modport source (
    output valid, head_valid, head_client, head_priority, head_tag, first_free_pos,
           first_limited_pos, client_present, all_same, entry_count, error_code,
    input  ready
  );
  modport sink (
    input  valid, head_valid, head_client, head_priority, head_tag, first_free_pos,
           first_limited_pos, client_present, all_same, entry_count, error_code,
    output ready
  );
endinterface

### rtl/core/ptrq_ctrl.sv
module ptrq_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            out_ready,
  output logic            out_valid,
  output ptrq_pkg::ctrl_t ctrl
);

  ptrq_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             load;

  assign load = (state_r == ptrq_pkg::ST_EVAL) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ptrq_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = ptrq_pkg::ST_EVAL;
      end
      ptrq_pkg::ST_EVAL: begin
        if (load) state_nxt = ptrq_pkg::ST_IDLE;
      end
      default: state_nxt = ptrq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    ctrl.exec = 1'b0;
    ctrl.load = 1'b0;
    case (state_r)
      ptrq_pkg::ST_IDLE: begin
        in_ready  = 1'b1;
        ctrl.exec = in_valid;
      end
      ptrq_pkg::ST_EVAL: begin
        ctrl.load = load;
      end
      default: ;
    endcase
  end

  assign out_valid_nxt = load ? 1'b1 : (out_valid_r && !out_ready);
  assign out_valid     = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ptrq_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### rtl/core/ptrq_dp.sv
module ptrq_dp #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ptrq_pkg::ctrl_t               ctrl,
  input  logic [1:0]                    command,
  input  logic [ptrq_pkg::ClientW-1:0]  entry_client,
  input  logic                          entry_priority,
  input  logic [ptrq_pkg::TagW-1:0]     entry_tag,
  input  logic [ptrq_pkg::PosW-1:0]     position,
  input  logic [ptrq_pkg::ClientW-1:0]  query_client,
  output ptrq_pkg::result_t             result
);

  localparam int unsigned PW  = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW  = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned AW  = (CW > ptrq_pkg::PosW) ? CW : ptrq_pkg::PosW;
  localparam int unsigned XPW = (PW > ptrq_pkg::PosW) ? PW : ptrq_pkg::PosW;
  localparam int unsigned XCW = (CW > ptrq_pkg::CountW) ? CW : ptrq_pkg::CountW;

  logic [ptrq_pkg::ClientW-1:0] client_r [QUEUE_DEPTH];
  logic                         prio_r   [QUEUE_DEPTH];
  logic [ptrq_pkg::TagW-1:0]    tag_r    [QUEUE_DEPTH];
  logic [CW-1:0]                count_r, count_nxt;
  ptrq_pkg::err_t               err_r, err_nxt;
  logic [ptrq_pkg::ClientW-1:0] qclient_r;
  ptrq_pkg::result_t            res_r, res_nxt;

  ptrq_pkg::cmd_t cmd;
  logic [AW-1:0]  cnt_a, pos_a, rm_a;
  logic           full, empty, do_ins, do_rm;

  // command decode and checks against the current count
  always_comb begin
    cmd     = ptrq_pkg::cmd_t'(command);
    cnt_a   = AW'(count_r);
    pos_a   = AW'(position);
    full    = (count_r == CW'(QUEUE_DEPTH));
    empty   = (count_r == '0);
    do_ins  = 1'b0;
    do_rm   = 1'b0;
    rm_a    = '0;
    err_nxt = ptrq_pkg::ERR_OK;
    case (cmd)
      ptrq_pkg::CMD_INSERT: begin
        if (full) err_nxt = ptrq_pkg::ERR_FULL;
        else      do_ins  = 1'b1;
      end
      ptrq_pkg::CMD_POP: begin
        if (empty) err_nxt = ptrq_pkg::ERR_EMPTY;
        else       do_rm   = 1'b1;
      end
      ptrq_pkg::CMD_DELETE: begin
        rm_a = pos_a;
        if (pos_a >= cnt_a) err_nxt = ptrq_pkg::ERR_POS_RANGE;
        else                do_rm   = 1'b1;
      end
      default: ;
    endcase
    count_nxt = count_r;
    if (do_ins)     count_nxt = count_r + CW'(1);
    else if (do_rm) count_nxt = count_r - CW'(1);
  end

  // queue cells: write at the tail, shift toward the head past a removed slot
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic wr_new, wr_shift;
    assign wr_new   = ctrl.exec && do_ins && (AW'(i) == cnt_a);
    if (i < QUEUE_DEPTH - 1) begin : g_sh
      assign wr_shift = ctrl.exec && do_rm && (AW'(i) >= rm_a);
      always_ff @(posedge clk) begin
        if (wr_new) begin
          client_r[i] <= entry_client;
          prio_r[i]   <= entry_priority;
          tag_r[i]    <= entry_tag;
        end else if (wr_shift) begin
          client_r[i] <= client_r[i+1];
          prio_r[i]   <= prio_r[i+1];
          tag_r[i]    <= tag_r[i+1];
        end
      end
    end else begin : g_last
      assign wr_shift = 1'b0;
      always_ff @(posedge clk) begin
        if (wr_new || wr_shift) begin
          client_r[i] <= entry_client;
          prio_r[i]   <= entry_priority;
          tag_r[i]    <= entry_tag;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (ctrl.exec) begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.exec) begin
      err_r     <= err_nxt;
      qclient_r <= query_client;
    end
  end

  // per-cell hit vectors over the updated queue
  logic [QUEUE_DEPTH-1:0] free_hit, lim_hit, cli_hit, free_iso, lim_iso;
  logic [PW-1:0]          free_idx, lim_idx;
  logic [XPW-1:0]         free_x, lim_x;
  logic [XCW-1:0]         cnt_x;

  always_comb begin
    for (int unsigned i = 0; i < QUEUE_DEPTH; i++) begin
      free_hit[i] = (AW'(i) < cnt_a) && !prio_r[i];
      lim_hit[i]  = (AW'(i) < cnt_a) && prio_r[i];
      cli_hit[i]  = (AW'(i) < cnt_a) && (client_r[i] == qclient_r);
    end
    // isolate lowest hit, then encode the one-hot position
    free_iso = free_hit & (~free_hit + QUEUE_DEPTH'(1));
    lim_iso  = lim_hit & (~lim_hit + QUEUE_DEPTH'(1));
    free_idx = '0;
    lim_idx  = '0;
    for (int unsigned i = 0; i < QUEUE_DEPTH; i++) begin
      if (free_iso[i]) free_idx = free_idx | PW'(i);
      if (lim_iso[i])  lim_idx  = lim_idx | PW'(i);
    end
    free_x = XPW'(free_idx);
    lim_x  = XPW'(lim_idx);
    cnt_x  = XCW'(count_r);

    res_nxt.head_valid        = !empty;
    res_nxt.head_client       = empty ? '0 : client_r[0];
    res_nxt.head_priority     = empty ? 1'b0 : prio_r[0];
    res_nxt.head_tag          = empty ? '0 : tag_r[0];
    res_nxt.first_free_pos    = free_x[ptrq_pkg::PosW-1:0];
    res_nxt.first_limited_pos = lim_x[ptrq_pkg::PosW-1:0];
    res_nxt.client_present    = |cli_hit;
    res_nxt.all_same          = !((|free_hit) && (|lim_hit));
    res_nxt.entry_count       = cnt_x[ptrq_pkg::CountW-1:0];
    res_nxt.error_code        = err_r;
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) res_r <= res_nxt;
  end

  assign result = res_r;

endmodule

### rtl/core/priority_tagged_request_queue_unit.sv
// channel   | dir | handshake     | payload
// ----------+-----+---------------+-------------------------------------------
// in_chan   | in  | valid / ready | command, entry fields, position, query id
// out_chan  | out | valid / ready | head entry, first positions, flags, count,
//           |     |               | error code
//
// each word is applied to the queue cells on the accept edge, and its report
// is captured into the output register in the eval state once that is free
// the report cycle is set by the per-cell compares and the lowest-hit encode
// reset clears the entry count, controller state and output valid; cell
// contents stay undefined until written
// a new word is taken while the previous report still waits; the report of
// that word is held back until the output register is emptied
module priority_tagged_request_queue_unit #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic  clk,
  input  logic  rst_n,
  ptrq_in_if.sink    in_chan,
  ptrq_out_if.source out_chan
);

  ptrq_pkg::ctrl_t   ctrl;
  ptrq_pkg::result_t result;

  // sequencing of accept and report
  ptrq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_ready (out_chan.ready),
    .out_valid (out_chan.valid),
    .ctrl      (ctrl)
  );

  // queue cells, compares and report register
  ptrq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctrl           (ctrl),
    .command        (in_chan.command),
    .entry_client   (in_chan.entry_client),
    .entry_priority (in_chan.entry_priority),
    .entry_tag      (in_chan.entry_tag),
    .position       (in_chan.position),
    .query_client   (in_chan.query_client),
    .result         (result)
  );

  // report word onto the output channel
  assign out_chan.head_valid        = result.head_valid;
  assign out_chan.head_client       = result.head_client;
  assign out_chan.head_priority     = result.head_priority;
  assign out_chan.head_tag          = result.head_tag;
  assign out_chan.first_free_pos    = result.first_free_pos;
  assign out_chan.first_limited_pos = result.first_limited_pos;
  assign out_chan.client_present    = result.client_present;
  assign out_chan.all_same          = result.all_same;
  assign out_chan.entry_count       = result.entry_count;
  assign out_chan.error_code        = result.error_code;

endmodule

### verif/ptrq_queue_checker.sv
module ptrq_queue_checker #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  ptrq_in_if          in_mon,
  ptrq_out_if         out_mon,
  output int unsigned fail_count,
  output int unsigned reports_due
);
  import ptrq_pkg::*;

  logic [ClientW-1:0] slot_client [QUEUE_DEPTH];
  logic               slot_prio   [QUEUE_DEPTH];
  logic [TagW-1:0]    slot_tag    [QUEUE_DEPTH];
  int unsigned        fill;
  result_t            expected_reports [$];

  initial begin
    fail_count  = 0;
    reports_due = 0;
    fill        = 0;
  end

  // later entries move one place toward the head
  function automatic void drop_slot(input int unsigned pos);
    for (int unsigned i = pos; i + 1 < fill; i++) begin
      slot_client[i] = slot_client[i + 1];
      slot_prio[i]   = slot_prio[i + 1];
      slot_tag[i]    = slot_tag[i + 1];
    end
    fill--;
  endfunction

  function automatic result_t apply_request(input cmd_t cmd, input logic [ClientW-1:0] client,
                                            input logic prio, input logic [TagW-1:0] tag,
                                            input logic [PosW-1:0] pos,
                                            input logic [ClientW-1:0] query_id);
    result_t     r;
    int unsigned ones;
    bit          got_free;
    bit          got_limited;
    r           = '0;
    ones        = 0;
    got_free    = 1'b0;
    got_limited = 1'b0;
    r.error_code = ERR_OK;
    case (cmd)
      CMD_INSERT: begin
        if (fill >= QUEUE_DEPTH) begin
          r.error_code = ERR_FULL;
        end else begin
          slot_client[fill] = client;
          slot_prio[fill]   = prio;
          slot_tag[fill]    = tag;
          fill++;
        end
      end
      CMD_POP: begin
        if (fill == 0) r.error_code = ERR_EMPTY;
        else drop_slot(0);
      end
      CMD_DELETE: begin
        if (pos >= fill) r.error_code = ERR_POS_RANGE;
        else drop_slot(pos);
      end
      default: ;
    endcase
    for (int unsigned i = 0; i < fill; i++) begin
      ones += slot_prio[i];
      if (!slot_prio[i] && !got_free) begin
        got_free         = 1'b1;
        r.first_free_pos = PosW'(i);
      end
      if (slot_prio[i] && !got_limited) begin
        got_limited         = 1'b1;
        r.first_limited_pos = PosW'(i);
      end
      if (slot_client[i] == query_id) r.client_present = 1'b1;
    end
    if (fill > 0) begin
      r.head_valid    = 1'b1;
      r.head_client   = slot_client[0];
      r.head_priority = slot_prio[0];
      r.head_tag      = slot_tag[0];
    end
    r.all_same    = (ones == 0 || ones == fill);
    r.entry_count = CountW'(fill);
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    result_t seen;
    result_t want;
    if (!rst_n) begin
      fill = 0;
      expected_reports.delete();
    end else begin
      if (in_mon.valid && in_mon.ready)
        expected_reports.insert(expected_reports.size(),
                                apply_request(cmd_t'(in_mon.command), in_mon.entry_client,
                                              in_mon.entry_priority, in_mon.entry_tag,
                                              in_mon.position, in_mon.query_client));
      if (out_mon.valid && out_mon.ready) begin
        seen = '{head_valid: out_mon.head_valid, head_client: out_mon.head_client,
                 head_priority: out_mon.head_priority, head_tag: out_mon.head_tag,
                 first_free_pos: out_mon.first_free_pos,
                 first_limited_pos: out_mon.first_limited_pos,
                 client_present: out_mon.client_present, all_same: out_mon.all_same,
                 entry_count: out_mon.entry_count, error_code: out_mon.error_code};
        if (expected_reports.size() == 0) begin
          $display("%0t: unexpected report, expected none, got %0h", $time, seen);
          fail_count++;
        end else begin
          want = expected_reports.pop_front();
          check_field("head_valid", want.head_valid, seen.head_valid);
          check_field("head_client", want.head_client, seen.head_client);
          check_field("head_priority", want.head_priority, seen.head_priority);
          check_field("head_tag", want.head_tag, seen.head_tag);
          check_field("first_free_pos", want.first_free_pos, seen.first_free_pos);
          check_field("first_limited_pos", want.first_limited_pos, seen.first_limited_pos);
          check_field("client_present", want.client_present, seen.client_present);
          check_field("all_same", want.all_same, seen.all_same);
          check_field("entry_count", want.entry_count, seen.entry_count);
          check_field("error_code", want.error_code, seen.error_code);
        end
      end
    end
    reports_due = expected_reports.size();
  end

endmodule

### verif/tb_priority_tagged_request_queue_unit.sv
module tb_priority_tagged_request_queue_unit;
  import ptrq_pkg::*;

  localparam int unsigned QUEUE_DEPTH  = 16;
  localparam int unsigned RANDOM_WORDS = 1725;
  // receiver hold-off long enough to back the queue up into the input
  localparam int unsigned LONG_HOLD    = 250;
  // cycles without any handshake before the run is declared hung
  localparam int unsigned IDLE_LIMIT   = 2000;
  // settle time after the last report
  localparam int unsigned DRAIN_CYCLES = 20;

  logic        clk;
  logic        rst_n;
  int unsigned fail_count;
  int unsigned reports_due;
  bit          send_burst;

  ptrq_in_if  in_if ();
  ptrq_out_if out_if ();

  priority_tagged_request_queue_unit #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_if),
    .out_chan(out_if)
  );

  // watches both channels, predicts every report and compares
  ptrq_queue_checker #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_if),
    .out_mon    (out_if),
    .fail_count (fail_count),
    .reports_due(reports_due)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // burst mode gives stretches with no idling at all
  function automatic int unsigned pick_gap(input bit burst);
    return burst ? 0 : $urandom_range(0, 8);
  endfunction

  // half the ids come from a small pool so searches actually hit
  function automatic logic [15:0] rand_client();
    return $urandom_range(0, 1) ? 16'($urandom_range(0, 7)) : 16'($urandom_range(0, 65535));
  endfunction

  // offer one word after a random gap and hold it until the block takes it
  // valid is only lowered when a gap is drawn, never dropped and raised in one step
  task automatic send_req(input cmd_t cmd, input logic [15:0] client, input logic prio,
                          input logic [31:0] tag, input logic [3:0] pos,
                          input logic [15:0] query_id);
    int unsigned gap;
    if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
    gap = pick_gap(send_burst);
    if (gap > 0) begin
      @(negedge clk);
      in_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_if.valid          <= 1'b1;
    in_if.command        <= cmd;
    in_if.entry_client   <= client;
    in_if.entry_priority <= prio;
    in_if.entry_tag      <= tag;
    in_if.position       <= pos;
    in_if.query_client   <= query_id;
    do @(posedge clk); while (in_if.ready !== 1'b1);
  endtask

  // stimulus and verdict
  initial begin
    int unsigned sent;
    int unsigned span;
    int unsigned insert_pct;
    cmd_t        cmd;
    in_if.valid          = 1'b0;
    in_if.command        = CMD_QUERY;
    in_if.entry_client   = '0;
    in_if.entry_priority = 1'b0;
    in_if.entry_tag      = '0;
    in_if.position       = '0;
    in_if.query_client   = '0;
    send_burst           = 1'b0;
    rst_n                = 1'b0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // empty queue: pop and delete both rejected, query reports nothing
    send_req(CMD_POP, 16'h0000, 1'b0, 32'h0, 4'd0, 16'h0000);
    send_req(CMD_DELETE, 16'h0000, 1'b0, 32'h0, 4'd0, 16'h0000);
    send_req(CMD_QUERY, 16'h0000, 1'b0, 32'h0, 4'd0, 16'h0000);
    // all-ones entry then all-zeros entry, mixed priorities
    send_req(CMD_INSERT, 16'hFFFF, 1'b1, 32'hFFFF_FFFF, 4'd0, 16'h0000);
    send_req(CMD_INSERT, 16'h0000, 1'b0, 32'h0000_0000, 4'd15, 16'hFFFF);
    send_req(CMD_QUERY, 16'h0000, 1'b0, 32'h0, 4'd0, 16'hFFFF);
    // delete past the count leaves the queue alone
    send_req(CMD_DELETE, 16'h0000, 1'b0, 32'h0, 4'd15, 16'h1234);
    // fill to the last slot
    for (int i = 2; i < QUEUE_DEPTH; i++)
      send_req(CMD_INSERT, 16'(i), 1'(i), $urandom(), 4'(i), 16'(i));
    // insert into a full queue is refused
    send_req(CMD_INSERT, 16'hABCD, 1'b1, 32'hDEAD_BEEF, 4'd0, 16'hABCD);
    // delete of the very last slot, then pop the head
    send_req(CMD_DELETE, 16'h0000, 1'b0, 32'h0, 4'd15, 16'h0005);
    send_req(CMD_POP, 16'h0000, 1'b0, 32'h0, 4'd0, 16'hFFFF);
    send_req(CMD_QUERY, 16'h0000, 1'b0, 32'h0, 4'd0, 16'h0003);

    // random phases that lean toward filling, balance or draining, so the
    // count keeps sweeping between empty and full
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      span = $urandom_range(20, 60);
      case ($urandom_range(0, 2))
        0:       insert_pct = 75;
        1:       insert_pct = 50;
        default: insert_pct = 20;
      endcase
      repeat (span) begin
        if ($urandom_range(0, 99) < insert_pct) begin
          cmd = CMD_INSERT;
        end else begin
          case ($urandom_range(0, 2))
            0:       cmd = CMD_POP;
            1:       cmd = CMD_DELETE;
            default: cmd = CMD_QUERY;
          endcase
        end
        send_req(cmd, rand_client(), 1'($urandom_range(0, 1)), $urandom(),
                 4'($urandom_range(0, 15)), rand_client());
        sent++;
      end
    end
    @(negedge clk);
    in_if.valid <= 1'b0;

    // drain, then give stray reports a chance to show up
    while (reports_due != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && reports_due == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // receiver: random stall before every report, with two long hold-offs
  // while the sender keeps offering so the block fills and stalls its input
  initial begin
    int unsigned stall;
    int unsigned taken;
    bit          burst;
    out_if.ready = 1'b0;
    taken        = 0;
    burst        = 1'b0;
    forever begin
      if ($urandom_range(0, 39) == 0) burst = !burst;
      stall = (taken == 150 || taken == 900) ? LONG_HOLD : pick_gap(burst);
      if (stall > 0) begin
        @(negedge clk);
        out_if.ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      out_if.ready <= 1'b1;
      do @(posedge clk); while (out_if.valid !== 1'b1);
      taken++;
    end
  end

  // watchdog: consecutive cycles with no handshake on either channel
  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
